FILE: hdl/pam_pkg.sv
// Shared types and codes for the polynomial accumulator ALU.
// Used by pam_front, pam_back, pam_mul and the top level.
package pam_pkg;

  localparam logic [3:0] CMD_CLEAR   = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_COPY    = 4'd2;
  localparam logic [3:0] CMD_ADD     = 4'd3;
  localparam logic [3:0] CMD_SUB     = 4'd4;
  localparam logic [3:0] CMD_MULT    = 4'd5;
  localparam logic [3:0] CMD_DIFF    = 4'd6;
  localparam logic [3:0] CMD_EVAL    = 4'd7;
  localparam logic [3:0] CMD_COMPOSE = 4'd8;

  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_BADLOAD,
    OP_COPY,
    OP_ADD,
    OP_SUB,
    OP_MULT,
    OP_DIFF,
    OP_EVAL,
    OP_COMPOSE
  } pam_op_e;

  typedef struct packed {
    pam_op_e     op;
    logic [4:0]  power;
    logic [63:0] coef;
    logic [63:0] point;
  } pam_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } pam_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } pam_mul_rsp_t;

endpackage

FILE: hdl/pam_mul.sv
// Multi-cycle 64x64 multiplier, low 64 bits of the product.
// One shared 32x32 multiplier, three partial products. Uses pam_pkg.
module pam_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pam_pkg::pam_mul_req_t req_i,
  output pam_pkg::pam_mul_rsp_t rsp_o
);
  import pam_pkg::*;

  logic        busy_q;
  logic [1:0]  ph_q;
  logic        done_q;
  logic [63:0] a_q, b_q, mp_q, sum_q;
  logic [31:0] ma, mb;
  logic [63:0] mx;

  always_comb begin
    case (ph_q)
      2'd1: begin
        ma = a_q[31:0];
        mb = b_q[63:32];
      end
      2'd2: begin
        ma = a_q[63:32];
        mb = b_q[31:0];
      end
      default: begin
        ma = a_q[31:0];
        mb = b_q[31:0];
      end
    endcase
    mx = 64'(ma) * 64'(mb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && busy_q && (ph_q == 2'd3);
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        busy_q <= 1'b1;
        ph_q   <= 2'd0;
        sum_q  <= '0;
      end else if (busy_q) begin
        mp_q <= mx;
        ph_q <= ph_q + 2'd1;
        case (ph_q)
          2'd1: sum_q <= mp_q;
          2'd2: sum_q <= sum_q + {mp_q[31:0], 32'b0};
          2'd3: begin
            sum_q  <= sum_q + {mp_q[31:0], 32'b0};
            busy_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = sum_q;

endmodule

FILE: hdl/pam_front.sv
// Front end: accepts items, classifies commands, two-entry queue to the back end.
// Uses pam_pkg.
module pam_front #(
  parameter int unsigned DegLim = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic [4:0]         term_power_i,
  input  logic [63:0]        term_coef_i,
  input  logic [63:0]        eval_point_i,
  output logic               q_valid_o,
  output pam_pkg::pam_item_t q_item_o,
  input  logic               q_pop_i
);
  import pam_pkg::*;

  pam_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       known;
  pam_op_e    op;
  logic       push;

  always_comb begin
    known = 1'b1;
    case (command_i)
      CMD_CLEAR:   op = OP_CLEAR;
      CMD_LOAD:    op = (term_power_i > 5'(DegLim)) ? OP_BADLOAD : OP_LOAD;
      CMD_COPY:    op = OP_COPY;
      CMD_ADD:     op = OP_ADD;
      CMD_SUB:     op = OP_SUB;
      CMD_MULT:    op = OP_MULT;
      CMD_DIFF:    op = OP_DIFF;
      CMD_EVAL:    op = OP_EVAL;
      CMD_COMPOSE: op = OP_COMPOSE;
      default: begin
        op    = OP_CLEAR;
        known = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && known;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{op: op, power: term_power_i, coef: term_coef_i, point: eval_point_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

FILE: hdl/pam_back.sv
// Back end: coefficient stores, command sequencer and result register.
// Uses pam_pkg and drives the shared pam_mul unit.
module pam_back #(
  parameter int unsigned DegLim = 31,
  parameter int unsigned CoefW  = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pam_pkg::pam_item_t    q_item_i,
  output logic                  q_pop_o,
  output pam_pkg::pam_mul_req_t mul_req_o,
  input  pam_pkg::pam_mul_rsp_t mul_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [4:0]            out_power_o,
  output logic [63:0]           out_coef_o,
  output logic [63:0]           eval_value_o,
  output logic                  status_o,
  output logic                  last_o
);
  import pam_pkg::*;

  localparam int unsigned NS = DegLim + 1;
  localparam int unsigned IW = $clog2(NS);
  localparam logic [IW-1:0] LastIdx = IW'(DegLim);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_ELEM  = 12'b0000_0000_0010,
    S_DMUL  = 12'b0000_0000_0100,
    S_DWAIT = 12'b0000_0000_1000,
    S_EMUL  = 12'b0000_0001_0000,
    S_EWAIT = 12'b0000_0010_0000,
    S_SCAN  = 12'b0000_0100_0000,
    S_PAIR  = 12'b0000_1000_0000,
    S_PWAIT = 12'b0001_0000_0000,
    S_CFIN  = 12'b0010_0000_0000,
    S_REMIT = 12'b0100_0000_0000,
    S_ONE   = 12'b1000_0000_0000
  } state_e;

  function automatic logic [63:0] sx(input logic [CoefW-1:0] v);
    logic signed [CoefW-1:0] s;
    s = v;
    return 64'(s);
  endfunction

  state_e            state_q;
  pam_op_e           op_q;
  logic [CoefW-1:0]  acc_q [NS];
  logic [CoefW-1:0]  opd_q [NS];
  logic [CoefW-1:0]  scr_q [NS];
  logic [CoefW-1:0]  h_q   [NS];
  logic [IW-1:0]     p_q, i_q, j_q, cur_q;
  logic [IW-1:0]     ahi_q, alo_q, ohi_q;
  logic              anz_q, onz_q, rep_q;
  logic [CoefW-1:0]  v_q, pt_q;
  logic              st_q;
  logic [63:0]       ev_q;
  logic              out_valid_q, out_status_q, out_last_q;
  logic [4:0]        out_power_q;
  logic [63:0]       out_coef_q, out_eval_q;

  logic [IW-1:0]     acc_ra, opd_ra, ij, i_nx, j_nx;
  logic [CoefW-1:0]  acc_rd, opd_rd, h_rd, scr_rd, src_rd, vn;
  logic              a_nz, o_nz, anz_n, onz_n, pair_fin, out_free, emit;
  logic [IW-1:0]     ahi_n, alo_n, ohi_n;
  logic              mult_bad, comp_bad;

  always_comb begin
    acc_ra = p_q;
    opd_ra = p_q;
    case (state_q)
      S_IDLE: opd_ra = q_item_i.power[IW-1:0];
      S_DMUL: acc_ra = (p_q == LastIdx) ? p_q : p_q + 1'b1;
      S_PAIR: begin
        acc_ra = i_q;
        opd_ra = j_q;
      end
      S_CFIN: acc_ra = cur_q;
      default: ;
    endcase
  end

  assign ij     = i_q + j_q;
  assign acc_rd = acc_q[acc_ra];
  assign opd_rd = opd_q[opd_ra];
  assign h_rd   = h_q[i_q];
  assign scr_rd = scr_q[ij];
  assign src_rd = (op_q == OP_COMPOSE) ? h_rd : acc_rd;
  assign vn     = mul_rsp_i.prod[CoefW-1:0] + acc_rd;

  always_comb begin
    mul_req_o.start = 1'b0;
    mul_req_o.a     = 64'(src_rd);
    mul_req_o.b     = 64'(opd_rd);
    case (state_q)
      S_DMUL: begin
        mul_req_o.start = (p_q != LastIdx);
        mul_req_o.a     = 64'(acc_rd);
        mul_req_o.b     = 64'(p_q) + 64'd1;
      end
      S_EMUL: begin
        mul_req_o.start = 1'b1;
        mul_req_o.a     = 64'(v_q);
        mul_req_o.b     = 64'(pt_q);
      end
      S_PAIR: mul_req_o.start = (src_rd != '0) && (opd_rd != '0);
      default: ;
    endcase
  end

  // degree / lowest-term trackers for the scan
  assign a_nz  = (acc_rd != '0);
  assign o_nz  = (opd_rd != '0);
  assign ahi_n = a_nz ? p_q : ahi_q;
  assign alo_n = (a_nz && !anz_q) ? p_q : alo_q;
  assign anz_n = anz_q || a_nz;
  assign ohi_n = o_nz ? p_q : ohi_q;
  assign onz_n = onz_q || o_nz;

  assign mult_bad = anz_n && onz_n &&
                    ((IW+1)'(ahi_n) + (IW+1)'(ohi_n) > (IW+1)'(DegLim));
  assign comp_bad = anz_n && onz_n && (ahi_n != '0) && (ohi_n != '0) &&
                    ((2*IW)'(ahi_n) * (2*IW)'(ohi_n) > (2*IW)'(DegLim));

  always_comb begin
    pair_fin = 1'b0;
    i_nx     = i_q;
    j_nx     = j_q + 1'b1;
    if (ij == LastIdx) begin
      j_nx = '0;
      if (i_q == LastIdx) pair_fin = 1'b1;
      else i_nx = i_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = out_free && ((state_q == S_REMIT && a_nz) || state_q == S_ONE);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_CLEAR;
      for (int k = 0; k < NS; k++) begin
        acc_q[k] <= '0;
        opd_q[k] <= '0;
        scr_q[k] <= '0;
        h_q[k]   <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            op_q  <= q_item_i.op;
            p_q   <= (q_item_i.op == OP_EVAL) ? LastIdx : '0;
            anz_q <= 1'b0;
            onz_q <= 1'b0;
            case (q_item_i.op)
              OP_CLEAR: for (int k = 0; k < NS; k++) opd_q[k] <= '0;
              OP_LOAD:  opd_q[opd_ra] <= opd_rd + q_item_i.coef[CoefW-1:0];
              OP_BADLOAD: begin
                st_q    <= 1'b1;
                ev_q    <= '0;
                state_q <= S_ONE;
              end
              OP_COPY: begin
                for (int k = 0; k < NS; k++) acc_q[k] <= opd_q[k];
                rep_q   <= 1'b1;
                state_q <= S_SCAN;
              end
              OP_ADD, OP_SUB: state_q <= S_ELEM;
              OP_DIFF:        state_q <= S_DMUL;
              OP_EVAL: begin
                v_q     <= '0;
                pt_q    <= q_item_i.point[CoefW-1:0];
                state_q <= S_EMUL;
              end
              OP_MULT, OP_COMPOSE: begin
                rep_q   <= 1'b0;
                state_q <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_ELEM: begin
          acc_q[p_q] <= (op_q == OP_SUB) ? acc_rd - opd_rd : acc_rd + opd_rd;
          if (p_q == LastIdx) begin
            p_q     <= '0;
            rep_q   <= 1'b1;
            state_q <= S_SCAN;
          end else begin
            p_q <= p_q + 1'b1;
          end
        end
        S_DMUL: begin
          if (p_q == LastIdx) begin
            acc_q[p_q] <= '0;
            p_q        <= '0;
            rep_q      <= 1'b1;
            state_q    <= S_SCAN;
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (mul_rsp_i.done) begin
            acc_q[p_q] <= mul_rsp_i.prod[CoefW-1:0];
            p_q        <= p_q + 1'b1;
            state_q    <= S_DMUL;
          end
        end
        S_EMUL: state_q <= S_EWAIT;
        S_EWAIT: begin
          if (mul_rsp_i.done) begin
            if (p_q == '0) begin
              st_q    <= 1'b0;
              ev_q    <= sx(vn);
              state_q <= S_ONE;
            end else begin
              v_q     <= vn;
              p_q     <= p_q - 1'b1;
              state_q <= S_EMUL;
            end
          end
        end
        S_SCAN: begin
          ahi_q <= ahi_n;
          alo_q <= alo_n;
          anz_q <= anz_n;
          ohi_q <= ohi_n;
          onz_q <= onz_n;
          if (p_q != LastIdx) begin
            p_q <= p_q + 1'b1;
          end else if (rep_q) begin
            if (!anz_n) begin
              st_q    <= 1'b0;
              ev_q    <= '0;
              state_q <= S_ONE;
            end else begin
              p_q     <= ahi_n;
              state_q <= S_REMIT;
            end
          end else if ((op_q == OP_MULT && mult_bad) ||
                       (op_q == OP_COMPOSE && comp_bad)) begin
            st_q    <= 1'b1;
            ev_q    <= '0;
            state_q <= S_ONE;
          end else if (op_q == OP_COMPOSE && !anz_n) begin
            // zero accumulator composes to zero
            p_q   <= '0;
            rep_q <= 1'b1;
          end else begin
            for (int k = 0; k < NS; k++) begin
              scr_q[k] <= '0;
              h_q[k]   <= '0;
            end
            cur_q   <= ahi_n;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (mul_req_o.start) begin
            state_q <= S_PWAIT;
          end else begin
            i_q <= i_nx;
            j_q <= j_nx;
            if (pair_fin) state_q <= S_CFIN;
          end
        end
        S_PWAIT: begin
          if (mul_rsp_i.done) begin
            scr_q[ij] <= scr_rd + mul_rsp_i.prod[CoefW-1:0];
            i_q       <= i_nx;
            j_q       <= j_nx;
            state_q   <= pair_fin ? S_CFIN : S_PAIR;
          end
        end
        S_CFIN: begin
          if (op_q == OP_MULT || cur_q == '0) begin
            for (int k = 1; k < NS; k++) acc_q[k] <= scr_q[k];
            acc_q[0] <= (op_q == OP_COMPOSE) ? scr_q[0] + acc_rd : scr_q[0];
            p_q     <= '0;
            anz_q   <= 1'b0;
            rep_q   <= 1'b1;
            state_q <= S_SCAN;
          end else begin
            for (int k = 1; k < NS; k++) h_q[k] <= scr_q[k];
            for (int k = 0; k < NS; k++) scr_q[k] <= '0;
            h_q[0]  <= scr_q[0] + acc_rd;
            cur_q   <= cur_q - 1'b1;
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_PAIR;
          end
        end
        S_REMIT: begin
          if (a_nz) begin
            if (out_free) begin
              out_power_q  <= 5'(p_q);
              out_coef_q   <= sx(acc_rd);
              out_eval_q   <= '0;
              out_status_q <= 1'b0;
              out_last_q   <= (p_q == alo_q);
              if (p_q == alo_q) state_q <= S_IDLE;
              else p_q <= p_q - 1'b1;
            end
          end else begin
            p_q <= p_q - 1'b1;
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_power_q  <= '0;
            out_coef_q   <= '0;
            out_eval_q   <= ev_q;
            out_status_q <= st_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_power_o  = out_power_q;
  assign out_coef_o   = out_coef_q;
  assign eval_value_o = out_eval_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

endmodule

FILE: hdl/polynomial_accumulator_alu.sv
// Polynomial accumulator ALU, top level. N = min(MAX_DEGREE,31)+1 coefficient slots.
// Add/sub/diff: a pass over the N slots, then a scan and report of the result. Eval:
// Horner's rule over the N slots on the shared multiplier. Mult: up to N(N+1)/2
// multiplier passes; compose repeats that once per accumulator degree. One item at
// a time in the back end; a 2-entry queue buffers input. Reset clears all coefficient
// stores at once; no clearing pass.
module polynomial_accumulator_alu #(
  parameter int unsigned MAX_DEGREE = 31,
  parameter int unsigned COEF_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [4:0]  term_power_i,
  input  logic [63:0] term_coef_i,
  input  logic [63:0] eval_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  out_power_o,
  output logic [63:0] out_coef_o,
  output logic [63:0] eval_value_o,
  output logic        status_o,
  output logic        last_o
);
  import pam_pkg::*;

  localparam int unsigned DegLim = (MAX_DEGREE < 31) ? MAX_DEGREE : 31;

  logic         q_valid, q_pop;
  pam_item_t    q_item;
  pam_mul_req_t mul_req;
  pam_mul_rsp_t mul_rsp;

  pam_front #(.DegLim(DegLim)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .term_power_i,
    .term_coef_i, .eval_point_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  pam_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));

  pam_back #(.DegLim(DegLim), .CoefW(COEF_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .mul_req_o(mul_req), .mul_rsp_i(mul_rsp),
    .out_valid_o, .out_stall_i, .out_power_o, .out_coef_o, .eval_value_o,
    .status_o, .last_o
  );

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && out_coef_o == 64'd0)
    else $error("refusal item not a lone last item");

  a_eval_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && eval_value_o != 64'd0 |-> last_o && !status_o && out_coef_o == 64'd0)
    else $error("eval value on a term item");

  a_term_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> out_coef_o != 64'd0)
    else $error("zero term reported before the last item");

endmodule
